// ----- hw/rtl/mtm_pkg.sv -----
// Package: shared constants and lane control type for the trimmed mean core.
package mtm_pkg;

   localparam int LANES               = 8;
   localparam int DEFAULT_CHANNELS    = 8;
   localparam int DEFAULT_SAMPLE_BITS = 12;
   localparam int ROUNDS              = 10;
   localparam int TRIM_SHIFT          = 3;
   localparam int SUM_EXTRA_BITS      = 4;
   localparam int ROUND_BITS          = $clog2(ROUNDS + 1);

   typedef struct packed {
      logic take;   // transaction accepted this cycle
      logic last;   // it is the final round of the burst
   } lane_ctrl_type;

endpackage

// ----- hw/rtl/multichannel_trimmed_mean_core.sv -----
// Top level: eight-channel ten-round trimmed mean averager.
//
//  channel | direction | handshake          | payload
//  req_    | in        | req_valid/req_stall | req_sample_ch0..7
//  rsp_    | out       | rsp_valid/rsp_stall | rsp_mean_ch0..7
//
// One request transaction per cycle while req_stall is low; every tenth one yields a
// response through the lane snapshot register, then the output register.
// Synchronous reset clears the lane accumulators and the round counter.
// req_stall rises only while both the snapshot and the output register hold
// data and rsp_stall is high. Channels at or above CHANNELS answer zero.
module multichannel_trimmed_mean_core #(
   parameter int CHANNELS    = mtm_pkg::DEFAULT_CHANNELS,
   parameter int SAMPLE_BITS = mtm_pkg::DEFAULT_SAMPLE_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [SAMPLE_BITS-1:0] req_sample_ch0,
   input  logic [SAMPLE_BITS-1:0] req_sample_ch1,
   input  logic [SAMPLE_BITS-1:0] req_sample_ch2,
   input  logic [SAMPLE_BITS-1:0] req_sample_ch3,
   input  logic [SAMPLE_BITS-1:0] req_sample_ch4,
   input  logic [SAMPLE_BITS-1:0] req_sample_ch5,
   input  logic [SAMPLE_BITS-1:0] req_sample_ch6,
   input  logic [SAMPLE_BITS-1:0] req_sample_ch7,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [SAMPLE_BITS-1:0] rsp_mean_ch0,
   output logic [SAMPLE_BITS-1:0] rsp_mean_ch1,
   output logic [SAMPLE_BITS-1:0] rsp_mean_ch2,
   output logic [SAMPLE_BITS-1:0] rsp_mean_ch3,
   output logic [SAMPLE_BITS-1:0] rsp_mean_ch4,
   output logic [SAMPLE_BITS-1:0] rsp_mean_ch5,
   output logic [SAMPLE_BITS-1:0] rsp_mean_ch6,
   output logic [SAMPLE_BITS-1:0] rsp_mean_ch7
);

   localparam int LANES    = mtm_pkg::LANES;
   localparam int SUM_BITS = SAMPLE_BITS + mtm_pkg::SUM_EXTRA_BITS;

   mtm_pkg::lane_ctrl_type ctrl;
   logic [SAMPLE_BITS-1:0] sample_all [LANES];
   logic [SAMPLE_BITS-1:0] mean_all   [LANES];
   logic [SUM_BITS-1:0]    snap_sum   [CHANNELS];
   logic [SAMPLE_BITS+1:0] snap_trim  [CHANNELS];
   logic [SAMPLE_BITS-1:0] mean       [CHANNELS];

   assign sample_all[0] = req_sample_ch0;
   assign sample_all[1] = req_sample_ch1;
   assign sample_all[2] = req_sample_ch2;
   assign sample_all[3] = req_sample_ch3;
   assign sample_all[4] = req_sample_ch4;
   assign sample_all[5] = req_sample_ch5;
   assign sample_all[6] = req_sample_ch6;
   assign sample_all[7] = req_sample_ch7;

   for (genvar g = 0; g < LANES; g++) begin : g_lane
      if (g < CHANNELS) begin : g_on
         mtm_lane #(
            .SAMPLE_BITS (SAMPLE_BITS)
         ) u_lane (
            .clock     (clock),
            .reset     (reset),
            .ctrl      (ctrl),
            .sample    (sample_all[g]),
            .snap_sum  (snap_sum[g]),
            .snap_trim (snap_trim[g])
         );
         assign mean_all[g] = mean[g];
      end else begin : g_off
         assign mean_all[g] = '0;
      end
   end

   mtm_merge #(
      .CHANNELS    (CHANNELS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_merge (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .ctrl      (ctrl),
      .snap_sum  (snap_sum),
      .snap_trim (snap_trim),
      .mean      (mean)
   );

   assign rsp_mean_ch0 = mean_all[0];
   assign rsp_mean_ch1 = mean_all[1];
   assign rsp_mean_ch2 = mean_all[2];
   assign rsp_mean_ch3 = mean_all[3];
   assign rsp_mean_ch4 = mean_all[4];
   assign rsp_mean_ch5 = mean_all[5];
   assign rsp_mean_ch6 = mean_all[6];
   assign rsp_mean_ch7 = mean_all[7];

endmodule

// ----- hw/rtl/mtm_lane.sv -----
// One channel lane: running sum, maximum and minimum, plus end-of-burst snapshot.
module mtm_lane #(
   parameter int SAMPLE_BITS = mtm_pkg::DEFAULT_SAMPLE_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  mtm_pkg::lane_ctrl_type               ctrl,
   input  logic [SAMPLE_BITS-1:0]               sample,
   output logic [SAMPLE_BITS+mtm_pkg::SUM_EXTRA_BITS-1:0] snap_sum,
   output logic [SAMPLE_BITS+1:0]               snap_trim
);

   localparam int SUM_BITS  = SAMPLE_BITS + mtm_pkg::SUM_EXTRA_BITS;
   localparam int MIN_BITS  = SAMPLE_BITS + 1;
   localparam int TRIM_BITS = SAMPLE_BITS + 2;
   localparam logic [MIN_BITS-1:0] MIN_RESET = MIN_BITS'(1) << SAMPLE_BITS;

   logic [SUM_BITS-1:0]    sum_ff, sum_in, sum_next;
   logic [SAMPLE_BITS-1:0] max_ff, max_in, max_next;
   logic [MIN_BITS-1:0]    min_ff, min_in, min_next;
   logic [SUM_BITS-1:0]    snap_sum_ff;
   logic [TRIM_BITS-1:0]   snap_trim_ff;
   logic [MIN_BITS-1:0]    sample_ext;

   always_comb begin
      sample_ext = MIN_BITS'(sample);
      max_next   = (sample > max_ff) ? sample : max_ff;
      min_next   = (sample_ext < min_ff) ? sample_ext : min_ff;
      sum_next   = sum_ff + SUM_BITS'(sample);
      sum_in     = sum_ff;
      max_in     = max_ff;
      min_in     = min_ff;
      if (ctrl.take) begin
         if (ctrl.last) begin
            sum_in = '0;
            max_in = '0;
            min_in = MIN_RESET;
         end else begin
            sum_in = sum_next;
            max_in = max_next;
            min_in = min_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
         max_ff <= '0;
         min_ff <= MIN_RESET;
      end else begin
         sum_ff <= sum_in;
         max_ff <= max_in;
         min_ff <= min_in;
      end
   end

   // snapshot of the completed burst, trimmed sum formed downstream
   always_ff @(posedge clock) begin
      if (ctrl.take && ctrl.last) begin
         snap_sum_ff  <= sum_next;
         snap_trim_ff <= TRIM_BITS'(max_next) + TRIM_BITS'(min_next);
      end
   end

   assign snap_sum  = snap_sum_ff;
   assign snap_trim = snap_trim_ff;

endmodule

// ----- hw/rtl/mtm_merge.sv -----
// Merge stage: round counter, flow control and trimmed-mean output register.
module mtm_merge #(
   parameter int CHANNELS    = mtm_pkg::DEFAULT_CHANNELS,
   parameter int SAMPLE_BITS = mtm_pkg::DEFAULT_SAMPLE_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output mtm_pkg::lane_ctrl_type        ctrl,
   input  logic [SAMPLE_BITS+mtm_pkg::SUM_EXTRA_BITS-1:0] snap_sum [CHANNELS],
   input  logic [SAMPLE_BITS+1:0]        snap_trim [CHANNELS],
   output logic [SAMPLE_BITS-1:0]        mean [CHANNELS]
);

   localparam int SUM_BITS  = SAMPLE_BITS + mtm_pkg::SUM_EXTRA_BITS;
   localparam int DIFF_BITS = SUM_BITS + 1;
   localparam int RB        = mtm_pkg::ROUND_BITS;
   localparam logic [RB-1:0] LAST_ROUND = RB'(mtm_pkg::ROUNDS - 1);

   logic [RB-1:0]          round_ff, round_in;
   logic                   snap_valid_ff, snap_valid_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   out_ready, snap_ready, take, last;
   logic [SAMPLE_BITS-1:0] mean_ff [CHANNELS];
   logic [SAMPLE_BITS-1:0] mean_in [CHANNELS];
   logic [DIFF_BITS-1:0]   diff    [CHANNELS];

   always_comb begin
      out_ready  = !rsp_valid_ff || !rsp_stall;
      snap_ready = !snap_valid_ff || out_ready;
      take       = req_valid && snap_ready;
      last       = (round_ff == LAST_ROUND);
      ctrl.take  = take;
      ctrl.last  = last;
      req_stall  = !snap_ready;

      round_in = round_ff;
      if (take) begin
         round_in = last ? '0 : round_ff + RB'(1);
      end

      priority if (take && last) begin
         snap_valid_in = 1'b1;
      end else if (snap_valid_ff && out_ready) begin
         snap_valid_in = 1'b0;
      end else begin
         snap_valid_in = snap_valid_ff;
      end

      rsp_valid_in = out_ready ? snap_valid_ff : rsp_valid_ff;

      for (int c = 0; c < CHANNELS; c++) begin
         diff[c] = DIFF_BITS'(snap_sum[c]) - DIFF_BITS'(snap_trim[c]);
         if (diff[c][DIFF_BITS-1]) begin
            mean_in[c] = '0;
         end else begin
            mean_in[c] = diff[c][mtm_pkg::TRIM_SHIFT +: SAMPLE_BITS];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         round_ff      <= '0;
         snap_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         round_ff      <= round_in;
         snap_valid_ff <= snap_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && snap_valid_ff) begin
         mean_ff <= mean_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign mean      = mean_ff;

endmodule

// ----- dv/tb.sv -----
// Testbench for the eight-channel ten-round trimmed mean core: directed and random rounds, self-checking.
module tb;

   typedef logic [mtm_pkg::LANES-1:0][11:0] sample_set_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic           req_valid  = 1'b0;
   logic           req_stall;
   sample_set_type req_sample = '0;
   logic           rsp_valid;
   logic           rsp_stall  = 1'b0;
   sample_set_type rsp_mean;

   sample_set_type rounds_pending[$];
   sample_set_type means_due[$];

   logic [15:0] lane_sum [mtm_pkg::LANES];
   logic [11:0] lane_max [mtm_pkg::LANES];
   logic [12:0] lane_min [mtm_pkg::LANES];
   logic [3:0]  burst_rounds;

   int rounds_accepted = 0;
   int means_checked   = 0;
   int mismatch_count  = 0;
   int hold_left       = 0;
   bit hold_done       = 1'b0;

   wire calm = rounds_accepted >= 600 && rounds_accepted < 750;
   wire hold = hold_left != 0;

   multichannel_trimmed_mean_core i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_sample_ch0 (req_sample[0]),
      .req_sample_ch1 (req_sample[1]),
      .req_sample_ch2 (req_sample[2]),
      .req_sample_ch3 (req_sample[3]),
      .req_sample_ch4 (req_sample[4]),
      .req_sample_ch5 (req_sample[5]),
      .req_sample_ch6 (req_sample[6]),
      .req_sample_ch7 (req_sample[7]),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_mean_ch0   (rsp_mean[0]),
      .rsp_mean_ch1   (rsp_mean[1]),
      .rsp_mean_ch2   (rsp_mean[2]),
      .rsp_mean_ch3   (rsp_mean[3]),
      .rsp_mean_ch4   (rsp_mean[4]),
      .rsp_mean_ch5   (rsp_mean[5]),
      .rsp_mean_ch6   (rsp_mean[6]),
      .rsp_mean_ch7   (rsp_mean[7])
   );

   always #1 clock = ~clock;

   task automatic clear_burst();
      for (int c = 0; c < mtm_pkg::LANES; c++) begin
         lane_sum[c] = '0;
         lane_max[c] = '0;
         lane_min[c] = 13'd4096;
      end
      burst_rounds = '0;
   endtask

   task automatic accumulate_round(input sample_set_type s);
      sample_set_type means;
      logic [16:0] trim;
      for (int c = 0; c < mtm_pkg::LANES; c++) begin
         if (s[c] > lane_max[c]) lane_max[c] = s[c];
         if ({1'b0, s[c]} < lane_min[c]) lane_min[c] = {1'b0, s[c]};
         lane_sum[c] = lane_sum[c] + 16'(s[c]);
      end
      burst_rounds = burst_rounds + 4'd1;
      if (burst_rounds >= 4'(mtm_pkg::ROUNDS)) begin
         for (int c = 0; c < mtm_pkg::LANES; c++) begin
            trim = 17'(lane_max[c]) + 17'(lane_min[c]);
            if (17'(lane_sum[c]) >= trim)
               means[c] = 12'((17'(lane_sum[c]) - trim) >> mtm_pkg::TRIM_SHIFT);
            else
               means[c] = '0;
         end
         means_due.push_back(means);
         clear_burst();
      end
   endtask

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10) $display("%s", msg);
   endtask

   // driver
   always @(posedge clock) begin : drive
      bit idle;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            accumulate_round(req_sample);
            rounds_accepted++;
         end
         if (!req_valid || !req_stall) begin
            idle = !calm && !hold && ($urandom_range(99) < 38);
            if (rounds_pending.size() != 0 && !idle) begin
               req_sample <= rounds_pending.pop_front();
               req_valid  <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin : observe
      sample_set_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            means_checked++;
            if (means_due.size() == 0) begin
               report_mismatch($sformatf("unexpected transaction: means %h", rsp_mean));
            end else begin
               want = means_due.pop_front();
               for (int c = 0; c < mtm_pkg::LANES; c++)
                  if (rsp_mean[c] !== want[c])
                     report_mismatch($sformatf("mean set %0d ch%0d: expected %0d, got %0d",
                                               means_checked, c, want[c], rsp_mean[c]));
            end
         end
         rsp_stall <= hold || (!calm && $urandom_range(99) < 38);
      end
   end

   // long output hold-off to back the core up
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (!hold_done && rounds_accepted >= 300) begin
         hold_left <= 200;
         hold_done <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   initial begin : stimulus
      sample_set_type s;
      int m;
      clear_burst();

      // all lanes at full scale
      for (int r = 0; r < mtm_pkg::ROUNDS; r++)
         rounds_pending.push_back({mtm_pkg::LANES{12'hfff}});
      // zero and full scale trimmed out of one burst
      for (int r = 0; r < mtm_pkg::ROUNDS; r++) begin
         for (int c = 0; c < mtm_pkg::LANES; c++)
            s[c] = (r == 0) ? 12'h000 : (r == 1) ? 12'hfff : 12'(c * 500 + r * 61);
         rounds_pending.push_back(s);
      end

      for (int i = 0; i < 1030; i++) begin
         for (int c = 0; c < mtm_pkg::LANES; c++) begin
            m = $urandom_range(99);
            if (m < 70)      s[c] = 12'($urandom_range(4095));
            else if (m < 85) s[c] = $urandom_range(1) ? 12'hfff : 12'h000;
            else             s[c] = 12'h800 ^ 12'($urandom_range(7));
         end
         rounds_pending.push_back(s);
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      do @(negedge clock);
      while (rounds_pending.size() != 0 || req_valid || means_due.size() != 0);
      repeat (20) @(negedge clock);

      $display("%0d rounds accepted, %0d mean sets checked, incl. a 200-cycle output hold-off",
               rounds_accepted, means_checked);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("%0d mismatches in total", mismatch_count);
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #200000;
      $display("Timed out");
      $display("Mismatches found");
      $finish;
   end

endmodule
